[sv/mcef_pkg.sv]
package mcef_pkg;

	// Channel count and derived sizes
	localparam int CHANNELS   = 16;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CTL_W      = 7;
	localparam int CTL_COLS   = 1 << CTL_W;
	localparam int ADDR_W     = CH_W + CTL_W;
	localparam int CTL_DEPTH  = CHANNELS * CTL_COLS;
	localparam int CLR_W      = $clog2(CTL_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOLO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYSEX = 2'd2;

	// Status types (high nibble)
	localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
	localparam logic [3:0] TYPE_CTL      = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
	localparam logic [3:0] TYPE_WHEEL    = 4'hE;
	localparam logic [3:0] TYPE_SYSTEM   = 4'hF;

	// System sub-codes (low nibble)
	localparam logic [3:0] SYS_SYSEX_F0  = 4'h0;
	localparam logic [3:0] SYS_SYSEX_F7  = 4'h7;
	localparam logic [3:0] SYS_META      = 4'hF;

	// Meta types
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [7:0] META_TIME_SIG = 8'h58;
	localparam logic [7:0] META_KEY_SIG  = 8'h59;
	localparam logic [7:0] KEY_SIG_LEN   = 8'd2;

	// Controllers of interest
	localparam logic [7:0] CC_RPN_SELECT = 8'd100;
	localparam logic [7:0] CC_DATA_ENTRY = 8'd6;
	localparam logic [7:0] RPN_BEND      = 8'd0;
	localparam logic [7:0] PROGRAM_IDX   = 8'd128;
	localparam logic [7:0] UNSET_BYTE    = 8'hFF;

	// Reset values
	localparam logic [23:0] TEMPO_RESET  = 24'h07A120;
	localparam logic [7:0]  TS_NUM_RESET = 8'd4;
	localparam logic [7:0]  TS_EXP_RESET = 8'd2;
	localparam logic [15:0] KEY_RESET    = 16'd0;
	localparam logic [6:0]  RANGE_RESET  = 7'd2;
	localparam logic [13:0] BEND_CENTRE  = 14'h2000;

	typedef struct packed {
		logic        action;
		logic [7:0]  status;
		logic [7:0]  data1;
		logic [6:0]  data2;
		logic [7:0]  meta_length;
		logic [7:0]  meta_byte0;
		logic [7:0]  meta_byte1;
		logic [7:0]  meta_byte2;
		logic [3:0]  query_channel;
		logic [7:0]  query_index;
	} ev_req_t;

	typedef struct packed {
		logic        forward;
		logic        rpn_send;
		logic [13:0] rpn_value;
		logic        sysex_forward;
		logic [7:0]  state_value;
		logic [13:0] bend_value;
		logic [6:0]  bend_range;
		logic [23:0] tempo;
		logic [7:0]  ts_numerator;
		logic [7:0]  ts_denominator_exp;
		logic [15:0] key_signature;
	} ev_res_t;

	// Access to the controller table
	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd;
		logic [ADDR_W-1:0] rd_addr;
	} tbl_req_t;

endpackage

[sv/midi_channel_event_filter.sv]
// Channel  Handshake               Payload
// ev       ev_valid / ev_ready     ev_req  (mcef_pkg::ev_req_t)
// res      res_valid / res_ready   res     (mcef_pkg::ev_res_t)
// cfg      cfg_we                  cfg_index, cfg_wdata (write only)
//
// One request per cycle while ev_ready is high; a result passes the controller
// table read stage, then the output register.
// After reset the controller table is swept to unset, all CHANNELS*128 entries
// (2048 here), with ev_ready low; configuration writes are taken meanwhile.
// A stalled result holds in the output register while one more request is
// taken into the read stage; ev_ready then falls until res_ready returns.
module midi_channel_event_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ev_valid,
	output logic                                 ev_ready,
	input  mcef_pkg::ev_req_t                    ev_req,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output mcef_pkg::ev_res_t                    res,
	input  logic                                 cfg_we,
	input  logic [mcef_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcef_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import mcef_pkg::*;

	ev_res_t    res_c;
	ev_res_t    res_s1;
	ev_res_t    merged;
	tbl_req_t   tbl;
	logic       use_table;
	logic       use_table_s1;
	logic       valid_s1;
	logic       busy;
	logic       fire;
	logic       advance;
	logic [7:0] rdata;

	assign advance  = valid_s1 && (!res_valid || res_ready);
	assign ev_ready = !busy && (!valid_s1 || !res_valid || res_ready);
	assign fire     = ev_valid && ev_ready;

	mcef_event u_event (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ev_req),
		.fire      (fire),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.res       (res_c),
		.use_table (use_table),
		.tbl       (tbl)
	);

	mcef_ctl_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.tbl    (tbl),
		.rdata  (rdata),
		.busy   (busy)
	);

	// Merge the table read into the result
	always_comb begin
		merged = res_s1;
		if (use_table_s1) begin
			merged.state_value = rdata;
		end
	end

	// Valid flags of read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// Payload: advance the read stage, hold the output while stalled
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1       <= res_c;
			use_table_s1 <= use_table;
		end
		if (advance) begin
			res <= merged;
		end
	end

endmodule

[sv/mcef_ctl_table.sv]
module mcef_ctl_table (
	input  logic               clk,
	input  logic               arst_n,
	input  mcef_pkg::tbl_req_t tbl,
	output logic [7:0]         rdata,
	output logic               busy
);
	import mcef_pkg::*;

	logic [7:0]       mem [CTL_DEPTH];
	logic [CLR_W-1:0] clr_q;

	assign busy = (clr_q != CLR_W'(CTL_DEPTH));

	// Sweep every entry to unset after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	// Write port: clearing pass first, then controller changes
	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[ADDR_W-1:0]] <= UNSET_BYTE;
		end else if (tbl.wr) begin
			mem[tbl.wr_addr] <= tbl.wr_data;
		end
	end

	// Registered read port; hold data until the next read
	always_ff @(posedge clk) begin
		if (tbl.rd) begin
			rdata <= mem[tbl.rd_addr];
		end
	end

endmodule

[sv/mcef_event.sv]
module mcef_event (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mcef_pkg::ev_req_t                    req,
	input  logic                                 fire,
	input  logic                                 cfg_we,
	input  logic [mcef_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcef_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output mcef_pkg::ev_res_t                    res,
	output logic                                 use_table,
	output mcef_pkg::tbl_req_t                   tbl
);
	import mcef_pkg::*;

	localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

	// Configuration
	logic [15:0] mute_q;
	logic [15:0] solo_q;
	logic        sysex_q;

	// Global meta state
	logic [23:0] tempo_q;
	logic [7:0]  ts_num_q;
	logic [7:0]  ts_exp_q;
	logic [15:0] key_q;

	// Per-channel state
	logic [6:0]  range_q [CHANNELS];
	logic [13:0] bend_q  [CHANNELS];
	logic [7:0]  rsel_q  [CHANNELS];
	logic [7:0]  rdat_q  [CHANNELS];
	logic [7:0]  prog_q  [CHANNELS];

	logic [3:0]      ev_type;
	logic [3:0]      ev_ch;
	logic            tracked;
	logic            q_tracked;
	logic [CH_W-1:0] ci;
	logic [CH_W-1:0] qi;
	logic [7:0]      sel_new;
	logic [7:0]      dat_new;
	logic            rpn_done;
	logic            is_event;
	logic            cc_upd;
	logic            prog_upd;
	logic            wheel_upd;
	logic            meta_ev;
	logic [13:0]     wheel_val;
	logic [23:0]     tempo_d;
	logic [7:0]      ts_num_d;
	logic [7:0]      ts_exp_d;
	logic [15:0]     key_d;

	// Decode the request and build the result
	always_comb begin
		ev_type   = req.status[7:4];
		ev_ch     = req.status[3:0];
		tracked   = ({1'b0, ev_ch} < CH_LIMIT);
		q_tracked = ({1'b0, req.query_channel} < CH_LIMIT);
		ci        = ev_ch[CH_W-1:0];
		qi        = req.query_channel[CH_W-1:0];
		is_event  = !req.action;

		// RPN select / data entry after this controller
		sel_new  = (req.data1 == CC_RPN_SELECT) ? {1'b0, req.data2} : rsel_q[ci];
		dat_new  = (req.data1 == CC_DATA_ENTRY) ? {1'b0, req.data2} : rdat_q[ci];
		rpn_done = (sel_new != UNSET_BYTE) && (dat_new != UNSET_BYTE);

		wheel_val = {req.data2, 7'b0} | {6'b0, req.data1};

		cc_upd    = is_event && (ev_type == TYPE_CTL) && tracked;
		prog_upd  = is_event && (ev_type == TYPE_PROGRAM) && tracked;
		wheel_upd = is_event && (ev_type == TYPE_WHEEL) && tracked;
		meta_ev   = is_event && (ev_type == TYPE_SYSTEM) && (ev_ch == SYS_META);

		// Meta updates
		tempo_d  = tempo_q;
		ts_num_d = ts_num_q;
		ts_exp_d = ts_exp_q;
		key_d    = key_q;
		if (meta_ev) begin
			if (req.data1 == META_TEMPO) begin
				tempo_d = {req.meta_byte0, req.meta_byte1, req.meta_byte2};
			end else if (req.data1 == META_TIME_SIG) begin
				ts_num_d = req.meta_byte0;
				ts_exp_d = req.meta_byte1;
			end else if (req.data1 == META_KEY_SIG && req.meta_length == KEY_SIG_LEN) begin
				key_d = {req.meta_byte0, req.meta_byte1};
			end
		end

		res       = '0;
		use_table = 1'b0;

		if (req.action) begin
			// Query: program from flops, controllers from the table
			if (q_tracked) begin
				res.bend_value = bend_q[qi];
				res.bend_range = range_q[qi];
				if (req.query_index == PROGRAM_IDX) begin
					res.state_value = prog_q[qi];
				end else if (!req.query_index[7]) begin
					use_table = 1'b1;
				end
			end
		end else begin
			case (ev_type)
				TYPE_NOTE_OFF, TYPE_PROGRAM, TYPE_WHEEL: res.forward = 1'b1;
				TYPE_NOTE_ON: begin
					res.forward = (req.data2 == 7'd0) ||
						(!mute_q[ev_ch] && (solo_q == 16'd0 || solo_q[ev_ch]));
				end
				TYPE_CTL: begin
					res.forward = 1'b1;
					if (tracked && rpn_done && sel_new == RPN_BEND) begin
						res.rpn_send  = 1'b1;
						res.rpn_value = {dat_new[6:0], 7'b0};
					end
				end
				TYPE_SYSTEM: begin
					res.sysex_forward = sysex_q &&
						(ev_ch == SYS_SYSEX_F0 || ev_ch == SYS_SYSEX_F7);
				end
				default: res.forward = 1'b0;
			endcase
		end

		res.tempo              = tempo_d;
		res.ts_numerator       = ts_num_d;
		res.ts_denominator_exp = ts_exp_d;
		res.key_signature      = key_d;

		// Controller table access
		tbl.wr      = fire && cc_upd && !req.data1[7];
		tbl.wr_addr = {ci, req.data1[CTL_W-1:0]};
		tbl.wr_data = {1'b0, req.data2};
		tbl.rd      = fire && use_table;
		tbl.rd_addr = {qi, req.query_index[CTL_W-1:0]};
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q  <= '0;
			solo_q  <= '0;
			sysex_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MUTE:  mute_q  <= cfg_wdata;
				CFG_SOLO:  solo_q  <= cfg_wdata;
				CFG_SYSEX: sysex_q <= cfg_wdata[0];
				default:   ;
			endcase
		end
	end

	// Per-channel and global state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				range_q[i] <= RANGE_RESET;
				bend_q[i]  <= BEND_CENTRE;
				rsel_q[i]  <= UNSET_BYTE;
				rdat_q[i]  <= UNSET_BYTE;
				prog_q[i]  <= '0;
			end
			tempo_q  <= TEMPO_RESET;
			ts_num_q <= TS_NUM_RESET;
			ts_exp_q <= TS_EXP_RESET;
			key_q    <= KEY_RESET;
		end else if (fire) begin
			tempo_q  <= tempo_d;
			ts_num_q <= ts_num_d;
			ts_exp_q <= ts_exp_d;
			key_q    <= key_d;
			if (cc_upd) begin
				if (rpn_done) begin
					// Drop the pair once both halves are seen
					rsel_q[ci] <= UNSET_BYTE;
					rdat_q[ci] <= UNSET_BYTE;
					if (sel_new == RPN_BEND) begin
						range_q[ci] <= dat_new[6:0];
					end
				end else begin
					rsel_q[ci] <= sel_new;
					rdat_q[ci] <= dat_new;
				end
			end
			if (prog_upd) begin
				prog_q[ci] <= req.data1;
			end
			if (wheel_upd) begin
				bend_q[ci] <= wheel_val;
			end
		end
	end

endmodule

[sv/mcef_checker.sv]
module mcef_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input mcef_pkg::ev_res_t res
);
	import mcef_pkg::*;

	// Stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// RPN value only with an RPN message, and always a whole range in the top bits
	a_rpn_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.rpn_send || res.rpn_value == 14'd0) &&
			res.rpn_value[6:0] == 7'd0)
		else $error("stray rpn value");

	// An RPN message only comes with a forwarded controller
	a_rpn_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.rpn_send |-> res.forward && !res.sysex_forward)
		else $error("rpn without forward");

	// Event flags exclude query fields
	a_event_query: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.forward || res.sysex_forward) |->
			res.state_value == 8'd0 && res.bend_value == 14'd0 &&
			res.bend_range == 7'd0)
		else $error("event result carries query data");

endmodule

bind midi_channel_event_filter mcef_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

[dv/midi_filter_monitor.sv]
`timescale 1ns / 100ps

module midi_filter_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ev_valid,
	input  logic                                 ev_ready,
	input  mcef_pkg::ev_req_t                    ev_req,
	input  logic                                 res_valid,
	input  logic                                 res_ready,
	input  mcef_pkg::ev_res_t                    res,
	input  logic                                 cfg_we,
	input  logic [mcef_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcef_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output int                                   mismatches,
	output int                                   outstanding
);
	import mcef_pkg::*;

	// Shadow copy of the channel state and the registers
	logic [7:0]  ctl_table [CHANNELS][int'(PROGRAM_IDX) + 1];
	logic [6:0]  bend_semis [CHANNELS];
	logic [13:0] wheel_pos [CHANNELS];
	logic [7:0]  rpn_sel [CHANNELS];
	logic [7:0]  rpn_dat [CHANNELS];
	logic [23:0] tempo_now;
	logic [7:0]  ts_num_now;
	logic [7:0]  ts_exp_now;
	logic [15:0] key_now;
	logic [15:0] mute_bits;
	logic [15:0] solo_bits;
	logic        sysex_on;

	ev_res_t predicted_results [$];

	task automatic clear_state();
		for (int c = 0; c < CHANNELS; c++) begin
			for (int i = 0; i < int'(PROGRAM_IDX); i++)
				ctl_table[c][i] = UNSET_BYTE;
			ctl_table[c][PROGRAM_IDX] = '0;
			bend_semis[c] = RANGE_RESET;
			wheel_pos[c]  = BEND_CENTRE;
			rpn_sel[c]    = UNSET_BYTE;
			rpn_dat[c]    = UNSET_BYTE;
		end
		tempo_now  = TEMPO_RESET;
		ts_num_now = TS_NUM_RESET;
		ts_exp_now = TS_EXP_RESET;
		key_now    = KEY_RESET;
		mute_bits  = '0;
		solo_bits  = '0;
		sysex_on   = 1'b1;
	endtask

	// Controller change: RPN select/data pairing, then the table write
	task automatic track_controller(input logic [3:0] ch, input logic [7:0] num,
			input logic [6:0] val, inout ev_res_t o);
		if (num == CC_RPN_SELECT)
			rpn_sel[ch] = {1'b0, val};
		if (num == CC_DATA_ENTRY)
			rpn_dat[ch] = {1'b0, val};
		if (rpn_sel[ch] != UNSET_BYTE && rpn_dat[ch] != UNSET_BYTE) begin
			if (rpn_sel[ch] == RPN_BEND) begin
				o.rpn_send   = 1'b1;
				o.rpn_value  = {rpn_dat[ch][6:0], 7'd0};
				bend_semis[ch] = rpn_dat[ch][6:0];
			end
			rpn_sel[ch] = UNSET_BYTE;
			rpn_dat[ch] = UNSET_BYTE;
		end
		if (num < PROGRAM_IDX)
			ctl_table[ch][num] = {1'b0, val};
	endtask

	// Work out the result of one request and advance the shadow state
	task automatic track_event(input ev_req_t q, output ev_res_t o);
		logic [3:0] kind;
		logic [3:0] ch;
		logic       tracked;
		o       = '0;
		kind    = q.status[7:4];
		ch      = q.status[3:0];
		tracked = int'(ch) < CHANNELS;
		if (q.action) begin
			if (int'(q.query_channel) < CHANNELS) begin
				if (q.query_index <= PROGRAM_IDX)
					o.state_value = ctl_table[q.query_channel][q.query_index];
				o.bend_value = wheel_pos[q.query_channel];
				o.bend_range = bend_semis[q.query_channel];
			end
		end else begin
			case (kind)
				TYPE_NOTE_OFF: o.forward = 1'b1;
				TYPE_NOTE_ON: begin
					o.forward = (q.data2 == '0) ||
						(!mute_bits[ch] && (solo_bits == '0 || solo_bits[ch]));
				end
				TYPE_CTL: begin
					o.forward = 1'b1;
					if (tracked)
						track_controller(ch, q.data1, q.data2, o);
				end
				TYPE_PROGRAM: begin
					o.forward = 1'b1;
					if (tracked)
						ctl_table[ch][PROGRAM_IDX] = q.data1;
				end
				TYPE_WHEEL: begin
					o.forward = 1'b1;
					if (tracked)
						wheel_pos[ch] = {q.data2, q.data1[6:0]} | {6'd0, q.data1};
				end
				TYPE_SYSTEM: begin
					if (ch == SYS_META) begin
						if (q.data1 == META_TEMPO) begin
							tempo_now = {q.meta_byte0, q.meta_byte1, q.meta_byte2};
						end else if (q.data1 == META_TIME_SIG) begin
							ts_num_now = q.meta_byte0;
							ts_exp_now = q.meta_byte1;
						end else if (q.data1 == META_KEY_SIG && q.meta_length == KEY_SIG_LEN) begin
							key_now = {q.meta_byte0, q.meta_byte1};
						end
					end
					if ((ch == SYS_SYSEX_F0 || ch == SYS_SYSEX_F7) && sysex_on)
						o.sysex_forward = 1'b1;
				end
				default: ;
			endcase
		end
		o.tempo              = tempo_now;
		o.ts_numerator       = ts_num_now;
		o.ts_denominator_exp = ts_exp_now;
		o.key_signature      = key_now;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare results first, then take new requests, then configuration
	always @(posedge clk or negedge arst_n) begin
		ev_res_t want;
		ev_res_t got;
		if (!arst_n) begin
			clear_state();
			predicted_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (predicted_results.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					got  = res;
					check_field("forward", want.forward, got.forward);
					check_field("rpn_send", want.rpn_send, got.rpn_send);
					check_field("rpn_value", want.rpn_value, got.rpn_value);
					check_field("sysex_forward", want.sysex_forward, got.sysex_forward);
					check_field("state_value", want.state_value, got.state_value);
					check_field("bend_value", want.bend_value, got.bend_value);
					check_field("bend_range", want.bend_range, got.bend_range);
					check_field("tempo", want.tempo, got.tempo);
					check_field("ts_numerator", want.ts_numerator, got.ts_numerator);
					check_field("ts_denominator_exp", want.ts_denominator_exp,
						got.ts_denominator_exp);
					check_field("key_signature", want.key_signature, got.key_signature);
				end
			end
			if (ev_valid && ev_ready) begin
				track_event(ev_req, want);
				predicted_results = {predicted_results, want};
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MUTE:  mute_bits = cfg_wdata;
					CFG_SOLO:  solo_bits = cfg_wdata;
					CFG_SYSEX: sysex_on  = cfg_wdata[0];
					default: ;
				endcase
			end
			outstanding = predicted_results.size();
		end
	end

endmodule

[dv/midi_channel_event_filter_test.sv]
`timescale 1ns / 100ps

module midi_channel_event_filter_test;
	import mcef_pkg::*;

	// Channel-message types with no handling in the block
	localparam logic [3:0] TYPE_POLY_TOUCH = 4'hA;
	localparam logic [3:0] TYPE_CHAN_TOUCH = 4'hD;

	logic                  clk;
	logic                  arst_n;
	logic                  ev_valid;
	logic                  ev_ready;
	ev_req_t               ev_req;
	logic                  res_valid;
	logic                  res_ready;
	ev_res_t               res;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    outstanding;

	bit quiet        = 1'b0;
	bit hold_results = 1'b0;

	midi_channel_event_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_ready  (ev_ready),
		.ev_req    (ev_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	midi_filter_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid    (ev_valid),
		.ev_ready    (ev_ready),
		.ev_req      (ev_req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop on a hung run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random back-pressure, or a long hold when asked
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				res_ready <= 1'b0;
				repeat (60) @(negedge clk);
				hold_results = 1'b0;
			end else begin
				res_ready <= quiet || ($urandom_range(99) >= 19);
			end
		end
	end

	function automatic ev_req_t make_event(input logic [3:0] kind, input logic [3:0] ch,
			input logic [7:0] d1, input logic [6:0] d2);
		ev_req_t r;
		r        = '0;
		r.status = {kind, ch};
		r.data1  = d1;
		r.data2  = d2;
		return r;
	endfunction

	function automatic ev_req_t make_meta(input logic [7:0] mtype, input logic [7:0] len,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		ev_req_t r;
		r = make_event(TYPE_SYSTEM, SYS_META, mtype, '0);
		r.meta_length = len;
		r.meta_byte0  = b0;
		r.meta_byte1  = b1;
		r.meta_byte2  = b2;
		return r;
	endfunction

	function automatic ev_req_t make_query(input logic [3:0] ch, input logic [7:0] idx);
		ev_req_t r;
		r               = '0;
		r.action        = 1'b1;
		r.query_channel = ch;
		r.query_index   = idx;
		return r;
	endfunction

	// Mostly well-formed events on a few channels, so RPN pairs and
	// controller read-backs happen often; the rest is raw noise
	function automatic ev_req_t random_request();
		ev_req_t      r;
		logic [95:0]  noise;
		int           pick;
		noise = {$urandom, $urandom, $urandom};
		r     = noise[$bits(ev_req_t)-1:0];
		pick  = $urandom_range(99);
		if (pick < 20)
			return r;
		r.action = (pick < 38);
		if (r.action) begin
			if ($urandom_range(1))
				r.query_channel = 4'($urandom_range(3));
			case ($urandom_range(5))
				0: r.query_index = CC_RPN_SELECT;
				1: r.query_index = CC_DATA_ENTRY;
				2: r.query_index = PROGRAM_IDX;
				3: r.query_index = 8'($urandom_range(7));
				default: r.query_index = 8'($urandom_range(255));
			endcase
			return r;
		end
		if ($urandom_range(1))
			r.status[3:0] = 4'($urandom_range(3));
		case ($urandom_range(9))
			0: r.status[7:4] = TYPE_NOTE_OFF;
			1, 2: begin
				r.status[7:4] = TYPE_NOTE_ON;
				if ($urandom_range(3) == 0)
					r.data2 = '0;
			end
			3, 4, 5: begin
				r.status[7:4] = TYPE_CTL;
				case ($urandom_range(5))
					0, 1: begin
						r.data1 = CC_RPN_SELECT;
						if ($urandom_range(1))
							r.data2 = '0;
					end
					2, 3: r.data1 = CC_DATA_ENTRY;
					4: r.data1 = 8'($urandom_range(7));
					default: ;
				endcase
			end
			6: r.status[7:4] = TYPE_PROGRAM;
			7: r.status[7:4] = TYPE_WHEEL;
			8: begin
				r.status = {TYPE_SYSTEM, SYS_META};
				case ($urandom_range(3))
					0: r.data1 = META_TEMPO;
					1: r.data1 = META_TIME_SIG;
					2: r.data1 = META_KEY_SIG;
					default: ;
				endcase
				if ($urandom_range(1))
					r.meta_length = KEY_SIG_LEN;
			end
			default: begin
				r.status[7:4] = TYPE_SYSTEM;
				case ($urandom_range(2))
					0: r.status[3:0] = SYS_SYSEX_F0;
					1: r.status[3:0] = SYS_SYSEX_F7;
					default: ;
				endcase
			end
		endcase
		return r;
	endfunction

	// Offer one request; starts and ends on a falling edge
	task automatic send_request(input ev_req_t r);
		if (!quiet && $urandom_range(99) < 19) begin
			ev_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 40);
		end
		ev_valid <= 1'b1;
		ev_req   <= r;
		do @(posedge clk); while (!ev_ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every request has its result back
	task automatic drain();
		ev_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		ev_valid  = 1'b0;
		ev_req    = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_MUTE;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults, all channels open, SysEx flagged
		write_reg(CFG_MUTE, 16'h0000);
		write_reg(CFG_SOLO, 16'h0000);
		write_reg(CFG_SYSEX, 16'h0001);

		// Unset controller, program and out-of-range index reads
		send_request(make_query(4'd0, 8'd0));
		send_request(make_query(4'd15, PROGRAM_IDX));
		send_request(make_query(4'd3, 8'd200));
		// Bend range RPN: select then data entry
		send_request(make_event(TYPE_CTL, 4'd2, CC_RPN_SELECT, 7'd0));
		send_request(make_event(TYPE_CTL, 4'd2, CC_DATA_ENTRY, 7'd127));
		send_request(make_query(4'd2, CC_DATA_ENTRY));
		// Other RPN: pair cleared without a message
		send_request(make_event(TYPE_CTL, 4'd4, CC_RPN_SELECT, 7'd5));
		send_request(make_event(TYPE_CTL, 4'd4, CC_DATA_ENTRY, 7'd9));
		// Controller number above the table
		send_request(make_event(TYPE_CTL, 4'd5, 8'd255, 7'd127));
		// Program 255 reads back as stored, not as never set
		send_request(make_event(TYPE_PROGRAM, 4'd15, 8'd255, 7'd0));
		send_request(make_query(4'd15, PROGRAM_IDX));
		// Pitch wheel with the top bit of data1 set
		send_request(make_event(TYPE_WHEEL, 4'd1, 8'hFF, 7'h7F));
		send_request(make_query(4'd1, 8'd127));
		// Meta events, key signature with the right and wrong length
		send_request(make_meta(META_TEMPO, 8'd0, 8'hFF, 8'hFF, 8'hFF));
		send_request(make_meta(META_TIME_SIG, 8'd7, 8'hFF, 8'h00, 8'h00));
		send_request(make_meta(META_KEY_SIG, KEY_SIG_LEN, 8'h80, 8'h7F, 8'h00));
		send_request(make_meta(META_KEY_SIG, 8'd3, 8'h11, 8'h22, 8'h33));
		send_request(make_meta(8'h00, 8'd255, 8'h01, 8'h02, 8'h03));
		// SysEx and ignored statuses
		send_request(make_event(TYPE_SYSTEM, SYS_SYSEX_F0, 8'd0, 7'd0));
		send_request(make_event(TYPE_SYSTEM, SYS_SYSEX_F7, 8'd0, 7'd0));
		send_request(make_event(TYPE_POLY_TOUCH, 4'd0, 8'd60, 7'd100));
		send_request(make_event(TYPE_CHAN_TOUCH, 4'd3, 8'd60, 7'd100));
		send_request(make_event(TYPE_NOTE_OFF, 4'd9, 8'd60, 7'd0));
		send_request(make_event(TYPE_NOTE_ON, 4'd0, 8'd60, 7'd127));

		// Everything muted, SysEx off
		drain();
		write_reg(CFG_MUTE, 16'hFFFF);
		write_reg(CFG_SYSEX, 16'h0000);
		send_request(make_event(TYPE_NOTE_ON, 4'd7, 8'd60, 7'd127));
		send_request(make_event(TYPE_NOTE_ON, 4'd7, 8'd60, 7'd0));
		send_request(make_event(TYPE_SYSTEM, SYS_SYSEX_F0, 8'd0, 7'd0));

		// Solo on the top channel only
		drain();
		write_reg(CFG_MUTE, 16'h0000);
		write_reg(CFG_SOLO, 16'h8000);
		send_request(make_event(TYPE_NOTE_ON, 4'd15, 8'd60, 7'd1));
		send_request(make_event(TYPE_NOTE_ON, 4'd0, 8'd60, 7'd1));

		// Solo on all, mute channel 0
		drain();
		write_reg(CFG_MUTE, 16'h0001);
		write_reg(CFG_SOLO, 16'hFFFF);
		send_request(make_event(TYPE_NOTE_ON, 4'd0, 8'd64, 7'd64));
		send_request(make_event(TYPE_NOTE_ON, 4'd1, 8'd64, 7'd64));

		// Random phases, each under its own mask setting
		for (int p = 0; p < 3; p++) begin
			drain();
			write_reg(CFG_MUTE, (p == 0) ? 16'h0000 : 16'($urandom & $urandom));
			write_reg(CFG_SOLO, (p == 1) ? 16'h0000 : 16'($urandom & $urandom));
			write_reg(CFG_SYSEX, 16'($urandom_range(1)));
			for (int n = 0; n < 250; n++) begin
				if (p == 1)
					quiet = (n >= 50 && n < 150);
				if (p == 2 && n == 60)
					hold_results = 1'b1;
				send_request(random_request());
			end
		end

		// Wait for the last results, then allow the pipeline to settle
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
